/* rtl/core/per_class_byte_quota_ledger_core_macros.svh */
// Assertion macros used by the controller of the per-class byte quota ledger.
`ifndef PER_CLASS_BYTE_QUOTA_LEDGER_CORE_MACROS_SVH
`define PER_CLASS_BYTE_QUOTA_LEDGER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCBQL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCBQL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pcbql_pkg.sv */
// Package with the types, constants and helpers of the per-class byte quota ledger.
package pcbql_pkg;

    localparam int NUM_CLASSES = 64;
    localparam int BYTE_W      = 48;
    localparam int COUNT_W     = 32;

    localparam int CLS_AW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int OP_W    = 4;
    localparam int CLS_W   = 6;
    localparam int AMT_W   = 48;
    localparam int SEL_W   = 4;
    localparam int RV_W    = 48;
    localparam int CMP_W   = 10;

    localparam int IN_BITS  = OP_W + CLS_W + AMT_W + SEL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 + RV_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]  BYTE_MAX  = {BYTE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 4'd0,
        OP_RELEASE = 4'd1,
        OP_HIT     = 4'd2,
        OP_MISS    = 4'd3,
        OP_EVICT   = 4'd4,
        OP_RD_BYTES = 4'd5,
        OP_WR_BYTES = 4'd6,
        OP_SET_LIMIT = 4'd7,
        OP_READ    = 4'd8
    } t_op;

    typedef enum logic [SEL_W-1:0] {
        SEL_LIMIT    = 4'd0,
        SEL_HELD     = 4'd1,
        SEL_PEAK     = 4'd2,
        SEL_GRANTS   = 4'd3,
        SEL_RELEASES = 4'd4,
        SEL_REFUSALS = 4'd5,
        SEL_ERRORS   = 4'd6,
        SEL_HITS     = 4'd7,
        SEL_MISSES   = 4'd8,
        SEL_EVICTS   = 4'd9,
        SEL_RD_BYTES = 4'd10,
        SEL_WR_BYTES = 4'd11,
        SEL_TOTAL    = 4'd12,
        SEL_TPEAK    = 4'd13
    } t_sel;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // One class record, kept as one memory row.
    typedef struct packed {
        logic [BYTE_W-1:0]  limit;
        logic [BYTE_W-1:0]  held;
        logic [BYTE_W-1:0]  peak;
        logic [COUNT_W-1:0] grants;
        logic [COUNT_W-1:0] releases;
        logic [COUNT_W-1:0] refusals;
        logic [COUNT_W-1:0] errors;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] misses;
        logic [COUNT_W-1:0] evicts;
        logic [BYTE_W-1:0]  rd_bytes;
        logic [BYTE_W-1:0]  wr_bytes;
    } t_rec;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

    function automatic t_rec rec_reset();
        t_rec r;
        r       = '0;
        r.limit = BYTE_MAX;
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        return (a > (BYTE_MAX - b)) ? BYTE_MAX : a + b;
    endfunction

endpackage

/* rtl/core/pcbql_ctrl.sv */
// Controller state machine that sequences load and execute of each ledger word.
`include "per_class_byte_quota_ledger_core_macros.svh"

module pcbql_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pcbql_pkg::t_sts i_sts,
    output pcbql_pkg::t_cmd o_cmd
);
    import pcbql_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold the fetched record until the result register can take the word.
                if (!i_sts.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `PCBQL_ASSERT_NEXT(a_load_to_exec, i_clk, i_rst_n, o_cmd.load, r_state == ST_EXEC,
        "accepted word did not move to execute")
    `PCBQL_ASSERT_NOW(a_exec_needs_room, i_clk, i_rst_n, o_cmd.exec,
        (r_state == ST_EXEC) && !i_sts.out_busy, "execute issued while result slot busy")
    `PCBQL_ASSERT_NEXT(a_exec_frees, i_clk, i_rst_n, (r_state == ST_EXEC) && !i_sts.out_busy,
        (r_state == ST_IDLE) && o_in_ready, "controller did not return to idle after execute")
    `PCBQL_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_cmd.load, !o_cmd.exec,
        "load and execute issued together")

endmodule

/* rtl/core/pcbql_dp.sv */
// Datapath with the class record memory, running totals and result register.
module pcbql_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcbql_pkg::t_cmd             i_cmd,
    output pcbql_pkg::t_sts             o_sts,
    input  logic [pcbql_pkg::OP_W-1:0]  i_opcode,
    input  logic [pcbql_pkg::CLS_W-1:0] i_class_index,
    input  logic [pcbql_pkg::AMT_W-1:0] i_amount,
    input  logic [pcbql_pkg::SEL_W-1:0] i_counter_select,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_granted,
    output logic                        o_accounting_error,
    output logic [pcbql_pkg::RV_W-1:0]  o_read_value
);
    import pcbql_pkg::*;

    t_rec                r_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_vld;

    logic [CLS_AW-1:0]   in_addr;
    logic [CLS_AW-1:0]   r_addr;
    logic [OP_W-1:0]     r_op;
    logic [SEL_W-1:0]    r_sel;
    logic [BYTE_W-1:0]   r_amt;
    t_rec                r_rd_rec;
    logic                r_rd_vld;

    logic [BYTE_W-1:0]   r_total;
    logic [BYTE_W-1:0]   r_tpeak;
    logic [BYTE_W-1:0]   n_total;
    logic [BYTE_W-1:0]   n_tpeak;

    logic                r_out_valid;
    logic                r_granted;
    logic                r_err;
    logic [RV_W-1:0]     r_rv;

    t_rec                cur;
    t_rec                nxt;
    logic                we;
    logic                granted;
    logic                err;
    logic [RV_W-1:0]     rv;
    logic                refuse;
    logic [BYTE_W-1:0]   held_new;
    logic [BYTE_W-1:0]   sum_total;

    // Classes beyond the table fold onto class 0.
    assign in_addr = (CMP_W'(i_class_index) < CMP_W'(NUM_CLASSES)) ?
                     CLS_AW'(i_class_index) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_rec <= r_mem[in_addr];
            r_addr   <= in_addr;
            r_op     <= i_opcode;
            r_sel    <= i_counter_select;
            r_amt    <= BYTE_W'(i_amount);
        end
        if (i_cmd.exec && we) begin
            r_mem[r_addr] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_total  <= '0;
            r_tpeak  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rd_vld <= r_vld[in_addr];
            end
            if (i_cmd.exec) begin
                r_total <= n_total;
                r_tpeak <= n_tpeak;
                if (we) begin
                    r_vld[r_addr] <= 1'b1;
                end
            end
        end
    end

    // A never-written class reads as its reset record.
    assign cur       = r_rd_vld ? r_rd_rec : rec_reset();
    assign held_new  = cur.held + r_amt;
    assign sum_total = r_total + r_amt;
    assign refuse    = (r_amt > cur.limit) || (cur.held > (cur.limit - r_amt)) ||
                       (r_amt > (BYTE_MAX - r_total));

    always_comb begin
        nxt     = cur;
        we      = 1'b0;
        granted = 1'b0;
        err     = 1'b0;
        rv      = '0;
        n_total = r_total;
        n_tpeak = r_tpeak;
        case (r_op)
            OP_RESERVE: begin
                we = 1'b1;
                if (refuse) begin
                    nxt.refusals = bump(cur.refusals);
                end else begin
                    nxt.held   = held_new;
                    nxt.grants = bump(cur.grants);
                    if (held_new > cur.peak) begin
                        nxt.peak = held_new;
                    end
                    n_total = sum_total;
                    if (sum_total > r_tpeak) begin
                        n_tpeak = sum_total;
                    end
                    granted = 1'b1;
                end
            end
            OP_RELEASE: begin
                we           = 1'b1;
                nxt.releases = bump(cur.releases);
                if ((r_amt > cur.held) || (r_amt > r_total)) begin
                    nxt.errors = bump(cur.errors);
                    n_total    = r_total - ((cur.held < r_total) ? cur.held : r_total);
                    nxt.held   = '0;
                    err        = 1'b1;
                end else begin
                    nxt.held = cur.held - r_amt;
                    n_total  = r_total - r_amt;
                end
            end
            OP_HIT: begin
                we       = 1'b1;
                nxt.hits = bump(cur.hits);
            end
            OP_MISS: begin
                we         = 1'b1;
                nxt.misses = bump(cur.misses);
            end
            OP_EVICT: begin
                we         = 1'b1;
                nxt.evicts = bump(cur.evicts);
            end
            OP_RD_BYTES: begin
                we           = 1'b1;
                nxt.rd_bytes = sat_add(cur.rd_bytes, r_amt);
            end
            OP_WR_BYTES: begin
                we           = 1'b1;
                nxt.wr_bytes = sat_add(cur.wr_bytes, r_amt);
            end
            OP_SET_LIMIT: begin
                we        = 1'b1;
                nxt.limit = r_amt;
            end
            OP_READ: begin
                case (r_sel)
                    SEL_LIMIT:    rv = RV_W'(cur.limit);
                    SEL_HELD:     rv = RV_W'(cur.held);
                    SEL_PEAK:     rv = RV_W'(cur.peak);
                    SEL_GRANTS:   rv = RV_W'(cur.grants);
                    SEL_RELEASES: rv = RV_W'(cur.releases);
                    SEL_REFUSALS: rv = RV_W'(cur.refusals);
                    SEL_ERRORS:   rv = RV_W'(cur.errors);
                    SEL_HITS:     rv = RV_W'(cur.hits);
                    SEL_MISSES:   rv = RV_W'(cur.misses);
                    SEL_EVICTS:   rv = RV_W'(cur.evicts);
                    SEL_RD_BYTES: rv = RV_W'(cur.rd_bytes);
                    SEL_WR_BYTES: rv = RV_W'(cur.wr_bytes);
                    SEL_TOTAL:    rv = RV_W'(r_total);
                    SEL_TPEAK:    rv = RV_W'(r_tpeak);
                    default:      rv = '0;
                endcase
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_granted <= granted;
            r_err     <= err;
            r_rv      <= rv;
        end
    end

    assign o_sts.out_busy     = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_granted          = r_granted;
    assign o_accounting_error = r_err;
    assign o_read_value       = r_rv;

endmodule

/* rtl/core/per_class_byte_quota_ledger_core.sv */
// Top level of the per-class byte quota ledger: stream ports, controller and datapath.
//
//   Channel   Dir   Word fields (lowest bit up)
//   s_axis    in    opcode[3:0], class_index[9:4], amount[57:10], counter_select[61:58]
//   m_axis    out   granted[0], accounting_error[1], read_value[49:2]
//
// Each word is first accepted and its class record is read from the record memory;
// then, in the execute state, the record is updated and written back.
// This split is set by the registered read port of the class record memory.
// A new word is accepted while the previous result still waits in the output register;
// a stalled output holds the second word in its execute cycle until the slot frees.
// Reset is synchronous and active low; the per-class valid bits clear at once,
// so no clearing pass is needed and the block is ready as soon as reset is released.
module per_class_byte_quota_ledger_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // opcode[3:0], class_index[9:4], amount[57:10], counter_select[61:58], zero pad
    input  logic [pcbql_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // granted[0], accounting_error[1], read_value[49:2], zero pad
    output logic [pcbql_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import pcbql_pkg::*;

    localparam int CLS_LO = OP_W;
    localparam int AMT_LO = OP_W + CLS_W;
    localparam int SEL_LO = OP_W + CLS_W + AMT_W;

    t_cmd            cmd;
    t_sts            sts;
    logic            granted;
    logic            acc_err;
    logic [RV_W-1:0] read_value;

    // The controller decides when a word is taken and when it is executed.
    pcbql_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds all ledger state and the result register.
    pcbql_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_opcode           (i_s_axis_tdata[OP_W-1:0]),
        .i_class_index      (i_s_axis_tdata[AMT_LO-1:CLS_LO]),
        .i_amount           (i_s_axis_tdata[SEL_LO-1:AMT_LO]),
        .i_counter_select   (i_s_axis_tdata[IN_BITS-1:SEL_LO]),
        .o_out_valid        (o_m_axis_tvalid),
        .i_out_ready        (i_m_axis_tready),
        .o_granted          (granted),
        .o_accounting_error (acc_err),
        .o_read_value       (read_value)
    );

    // Pack the result word; the pad bits above the fields are zero.
    assign o_m_axis_tdata = OUT_W'({read_value, acc_err, granted});

endmodule

/* test/per_class_byte_quota_ledger_checker.sv */
// Result checker for the per-class byte quota ledger: predicts every result word and compares it.
`timescale 1ns / 1ps
module per_class_byte_quota_ledger_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    // opcode, class_index, amount, counter_select, zero pad
    input  logic [pcbql_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // granted, accounting_error, read_value, zero pad
    input  logic [pcbql_pkg::OUT_W-1:0] i_m_tdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_grants,
    output int                          o_errors
);
    import pcbql_pkg::*;

    typedef struct packed {
        logic            granted;
        logic            acct_err;
        logic [RV_W-1:0] value;
    } ledger_result_t;

    ledger_result_t awaited_results[$];

    // Shadow copy of the ledger.
    logic [BYTE_W-1:0]  lim_q     [NUM_CLASSES];
    logic [BYTE_W-1:0]  held_q    [NUM_CLASSES];
    logic [BYTE_W-1:0]  peak_q    [NUM_CLASSES];
    logic [BYTE_W-1:0]  rd_sum    [NUM_CLASSES];
    logic [BYTE_W-1:0]  wr_sum    [NUM_CLASSES];
    logic [COUNT_W-1:0] grant_n   [NUM_CLASSES];
    logic [COUNT_W-1:0] release_n [NUM_CLASSES];
    logic [COUNT_W-1:0] refusal_n [NUM_CLASSES];
    logic [COUNT_W-1:0] error_n   [NUM_CLASSES];
    logic [COUNT_W-1:0] hit_n     [NUM_CLASSES];
    logic [COUNT_W-1:0] miss_n    [NUM_CLASSES];
    logic [COUNT_W-1:0] evict_n   [NUM_CLASSES];
    logic [BYTE_W-1:0]  total_held;
    logic [BYTE_W-1:0]  total_peak;

    int fail_count = 0;
    int checked_n  = 0;
    int grants_n   = 0;
    int errors_n   = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked_n;
    assign o_grants     = grants_n;
    assign o_errors     = errors_n;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
        return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_bytes(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        return (a > ({BYTE_W{1'b1}} - b)) ? {BYTE_W{1'b1}} : a + b;
    endfunction

    // Applies one input word to the shadow ledger and returns the result it should cause.
    function automatic ledger_result_t ledger_apply(input logic [IN_W-1:0] w);
        logic [OP_W-1:0]   op;
        logic [CLS_W-1:0]  cls;
        logic [BYTE_W-1:0] amt;
        logic [SEL_W-1:0]  sel;
        int                c;
        ledger_result_t    r;
        op  = w[OP_W-1:0];
        cls = w[OP_W +: CLS_W];
        amt = w[OP_W+CLS_W +: AMT_W];
        sel = w[OP_W+CLS_W+AMT_W +: SEL_W];
        c   = (int'(cls) < NUM_CLASSES) ? int'(cls) : 0;
        r   = '0;
        case (op)
            OP_RESERVE: begin
                if (amt > lim_q[c] || held_q[c] > lim_q[c] - amt ||
                    amt > BYTE_MAX - total_held) begin
                    refusal_n[c] = sat_count(refusal_n[c]);
                end else begin
                    held_q[c] = held_q[c] + amt;
                    if (held_q[c] > peak_q[c]) begin
                        peak_q[c] = held_q[c];
                    end
                    grant_n[c] = sat_count(grant_n[c]);
                    total_held = total_held + amt;
                    if (total_held > total_peak) begin
                        total_peak = total_held;
                    end
                    r.granted = 1'b1;
                end
            end
            OP_RELEASE: begin
                release_n[c] = sat_count(release_n[c]);
                if (amt > held_q[c] || amt > total_held) begin
                    error_n[c] = sat_count(error_n[c]);
                    total_held = total_held -
                                 ((held_q[c] < total_held) ? held_q[c] : total_held);
                    held_q[c]  = '0;
                    r.acct_err = 1'b1;
                end else begin
                    held_q[c]  = held_q[c] - amt;
                    total_held = total_held - amt;
                end
            end
            OP_HIT:       hit_n[c]   = sat_count(hit_n[c]);
            OP_MISS:      miss_n[c]  = sat_count(miss_n[c]);
            OP_EVICT:     evict_n[c] = sat_count(evict_n[c]);
            OP_RD_BYTES:  rd_sum[c]  = sat_bytes(rd_sum[c], amt);
            OP_WR_BYTES:  wr_sum[c]  = sat_bytes(wr_sum[c], amt);
            OP_SET_LIMIT: lim_q[c]   = amt;
            OP_READ: begin
                case (sel)
                    SEL_LIMIT:    r.value = RV_W'(lim_q[c]);
                    SEL_HELD:     r.value = RV_W'(held_q[c]);
                    SEL_PEAK:     r.value = RV_W'(peak_q[c]);
                    SEL_GRANTS:   r.value = RV_W'(grant_n[c]);
                    SEL_RELEASES: r.value = RV_W'(release_n[c]);
                    SEL_REFUSALS: r.value = RV_W'(refusal_n[c]);
                    SEL_ERRORS:   r.value = RV_W'(error_n[c]);
                    SEL_HITS:     r.value = RV_W'(hit_n[c]);
                    SEL_MISSES:   r.value = RV_W'(miss_n[c]);
                    SEL_EVICTS:   r.value = RV_W'(evict_n[c]);
                    SEL_RD_BYTES: r.value = RV_W'(rd_sum[c]);
                    SEL_WR_BYTES: r.value = RV_W'(wr_sum[c]);
                    SEL_TOTAL:    r.value = RV_W'(total_held);
                    SEL_TPEAK:    r.value = RV_W'(total_peak);
                    default:      r.value = '0;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
                 checked_n, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        ledger_result_t want;
        ledger_result_t got;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                lim_q[k]     = BYTE_MAX;
                held_q[k]    = '0;
                peak_q[k]    = '0;
                rd_sum[k]    = '0;
                wr_sum[k]    = '0;
                grant_n[k]   = '0;
                release_n[k] = '0;
                refusal_n[k] = '0;
                error_n[k]   = '0;
                hit_n[k]     = '0;
                miss_n[k]    = '0;
                evict_n[k]   = '0;
            end
            total_held = '0;
            total_peak = '0;
            awaited_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(ledger_apply(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.granted  = i_m_tdata[0];
                got.acct_err = i_m_tdata[1];
                got.value    = i_m_tdata[2 +: RV_W];
                if (awaited_results.size() == 0) begin
                    report_mismatch("result word with nothing outstanding",
                                    64'(i_m_tdata), 64'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.granted !== want.granted) begin
                        report_mismatch("granted", 64'(got.granted), 64'(want.granted));
                    end
                    if (got.acct_err !== want.acct_err) begin
                        report_mismatch("accounting_error", 64'(got.acct_err),
                                        64'(want.acct_err));
                    end
                    if (got.value !== want.value) begin
                        report_mismatch("read_value", 64'(got.value), 64'(want.value));
                    end
                    checked_n++;
                    if (want.granted) begin
                        grants_n++;
                    end
                    if (want.acct_err) begin
                        errors_n++;
                    end
                end
            end
        end
        o_pending <= awaited_results.size();
    end

endmodule

/* test/per_class_byte_quota_ledger_core_test.sv */
// Top of the per-class byte quota ledger testbench: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps
module per_class_byte_quota_ledger_core_test;
    import pcbql_pkg::*;

    // Opcodes and counter selects that the block does not define. They must leave the
    // ledger untouched and give an all-zero result.
    localparam logic [OP_W-1:0]  OP_UNUSED_FIRST  = 4'd9;
    localparam logic [OP_W-1:0]  OP_UNUSED_LAST   = 4'd15;
    localparam logic [SEL_W-1:0] SEL_UNUSED_LAST  = 4'd15;
    // Counter select carried by words that are not counter reads.
    localparam logic [SEL_W-1:0] SEL_NONE         = '0;
    localparam logic [BYTE_W-1:0] HALF_SPAN       = {1'b1, {(BYTE_W-1){1'b0}}};

    localparam int RANDOM_WORDS  = 400;
    localparam int DRAIN_EVERY   = 100;
    // Idle time after the final drain that covers any trailing result.
    localparam int SETTLE_CYCLES = 8;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    int fail_count;
    int pending;
    int results_checked;
    int grants_seen;
    int errors_seen;

    int words_sent     = 0;
    int directed_words = 0;
    bit sender_eager   = 1'b0;

    per_class_byte_quota_ledger_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // The checker watches both channels on its own; this module only drives stimulus.
    per_class_byte_quota_ledger_checker ledger_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (results_checked),
        .o_grants     (grants_seen),
        .o_errors     (errors_seen)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle stretch length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input int min_len);
        int roll;
        int len;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            len = 0;
        end else if (roll < 93) begin
            len = $urandom_range(1, 3);
        end else begin
            len = $urandom_range(10, 40);
        end
        return (len < min_len) ? min_len : len;
    endfunction

    // Amounts lean toward small values so that reserves fit and releases balance, with
    // zero, the largest byte value, values just under it and full-width random values mixed in.
    function automatic logic [BYTE_W-1:0] pick_amount();
        logic [63:0] wide;
        int          roll;
        wide = {$urandom, $urandom};
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            return BYTE_W'($urandom_range(0, 4095));
        end else if (roll < 7) begin
            return wide[BYTE_W-1:0];
        end else if (roll < 8) begin
            return BYTE_MAX;
        end else if (roll < 9) begin
            return BYTE_MAX - BYTE_W'($urandom_range(0, 255));
        end
        return '0;
    endfunction

    // A few classes get most of the traffic so their holdings and counters build up.
    function automatic logic [CLS_W-1:0] pick_class();
        if ($urandom_range(0, 9) < 6) begin
            return CLS_W'($urandom_range(0, 3));
        end
        return CLS_W'($urandom_range(0, (1 << CLS_W) - 1));
    endfunction

    function automatic logic [SEL_W-1:0] pick_sel();
        return SEL_W'($urandom_range(0, int'(SEL_UNUSED_LAST)));
    endfunction

    // Presents one word and returns at the clock edge where it is taken. The valid stays
    // high straight into the next word when no gap follows.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [CLS_W-1:0] cls,
                             input logic [BYTE_W-1:0] amt, input logic [SEL_W-1:0] sel);
        int gap;
        gap = sender_eager ? 0 : pick_gap(0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({sel, amt, cls, op});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Holds the sender off until every result that is owed has come back.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Well-formed quota traffic on one class: an optional new limit, a reserve, some
    // usage events, a counter read, and most of the time a matching release. Some
    // releases ask for more than was reserved and some are left out on purpose.
    task automatic quota_sequence();
        logic [CLS_W-1:0]  cls;
        logic [BYTE_W-1:0] amt;
        logic [BYTE_W-1:0] new_limit;
        int                roll;
        cls = pick_class();
        amt = BYTE_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 3) == 0) begin
            new_limit = ($urandom_range(0, 2) == 0) ? BYTE_MAX
                                                    : BYTE_W'($urandom_range(0, 6000));
            send_word(OP_SET_LIMIT, cls, new_limit, pick_sel());
        end
        send_word(OP_RESERVE, cls, amt, pick_sel());
        repeat ($urandom_range(0, 3)) begin
            send_word(OP_W'($urandom_range(int'(OP_HIT), int'(OP_WR_BYTES))), cls,
                      BYTE_W'($urandom_range(0, 4095)), pick_sel());
        end
        send_word(OP_READ, cls, pick_amount(), pick_sel());
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
            send_word(OP_RELEASE, cls, amt + BYTE_W'($urandom_range(1, 4096)), pick_sel());
        end else if (roll < 9) begin
            send_word(OP_RELEASE, cls, amt, pick_sel());
        end
    endtask

    // Any word at all, undefined opcodes and selects included.
    task automatic noise_word();
        send_word(OP_W'($urandom_range(0, int'(OP_UNUSED_LAST))),
                  CLS_W'($urandom_range(0, (1 << CLS_W) - 1)), pick_amount(), pick_sel());
    endtask

    // The result side takes open stretches of varying length and then stalls.
    initial begin : result_sink
        int len;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(30, 200);
            end else begin
                len = $urandom_range(1, 8);
            end
            m_tready <= 1'b1;
            repeat (len) @(posedge clk);
            len = pick_gap(1);
            m_tready <= 1'b0;
            repeat (len) @(posedge clk);
        end
    end

    initial begin : stimulus
        int last_drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Class 5 walks through a grant of nothing, a plain grant, a refusal
        // under a reduced limit, an exact fit and a release larger than the holding.
        send_word(OP_READ, 6'd63, '0, SEL_LIMIT);
        send_word(OP_RESERVE, 6'd5, '0, SEL_NONE);
        send_word(OP_RESERVE, 6'd5, 48'd1000, SEL_NONE);
        send_word(OP_SET_LIMIT, 6'd5, 48'd1500, SEL_NONE);
        send_word(OP_RESERVE, 6'd5, 48'd600, SEL_NONE);
        send_word(OP_RESERVE, 6'd5, 48'd500, SEL_NONE);
        send_word(OP_READ, 6'd5, '0, SEL_PEAK);
        send_word(OP_RELEASE, 6'd5, 48'd2000, SEL_NONE);
        send_word(OP_READ, 6'd5, '0, SEL_ERRORS);
        // Usage events at both ends of the class range.
        send_word(OP_HIT, 6'd63, '0, SEL_NONE);
        send_word(OP_MISS, 6'd0, '0, SEL_NONE);
        send_word(OP_EVICT, 6'd1, '0, SEL_NONE);
        // Byte sums driven into saturation.
        send_word(OP_RD_BYTES, 6'd2, BYTE_MAX, SEL_NONE);
        send_word(OP_RD_BYTES, 6'd2, 48'd1, SEL_NONE);
        send_word(OP_WR_BYTES, 6'd2, HALF_SPAN, SEL_NONE);
        send_word(OP_WR_BYTES, 6'd2, HALF_SPAN, SEL_NONE);
        send_word(OP_READ, 6'd2, '0, SEL_RD_BYTES);
        send_word(OP_READ, 6'd2, '0, SEL_WR_BYTES);
        // One class takes the whole byte range, so any further nonzero reserve would overflow
        // the total and must be refused even on an unlimited class.
        send_word(OP_RESERVE, 6'd7, BYTE_MAX, SEL_NONE);
        send_word(OP_RESERVE, 6'd8, 48'd1, SEL_NONE);
        send_word(OP_READ, 6'd0, '0, SEL_TPEAK);
        send_word(OP_RELEASE, 6'd7, BYTE_MAX, SEL_NONE);
        send_word(OP_READ, 6'd0, '0, SEL_TOTAL);
        // A zero limit refuses everything but a zero reserve.
        send_word(OP_SET_LIMIT, 6'd9, '0, SEL_NONE);
        send_word(OP_RESERVE, 6'd9, 48'd1, SEL_NONE);
        // Undefined opcode and select, with every bit of every field set.
        send_word(OP_UNUSED_LAST, 6'd63, BYTE_MAX, SEL_UNUSED_LAST);
        send_word(OP_UNUSED_FIRST, 6'd3, 48'd77, SEL_NONE);
        send_word(OP_READ, 6'd5, BYTE_MAX, SEL_UNUSED_LAST);
        directed_words = words_sent;

        // Random part: mostly quota sequences, the rest noise. Now and then the sender
        // runs without gaps, and every so often it waits for all results to come back.
        last_drain = words_sent;
        while (words_sent < directed_words + RANDOM_WORDS) begin
            sender_eager = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7) begin
                quota_sequence();
            end else begin
                repeat ($urandom_range(1, 4)) noise_word();
            end
            if (words_sent - last_drain >= DRAIN_EVERY) begin
                wait_for_drain();
                last_drain = words_sent;
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d words: %0d directed, the rest random quota sequences and noise,",
                 words_sent, directed_words);
        $display("all opcodes and selects incl. undefined ones; %0d results, %0d grants, %0d errors.",
                 results_checked, grants_seen, errors_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every word meeting the longest gap and stall.
    initial begin : watchdog
        #10_000_000;
        $display("Timeout with %0d results still outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/pcbql_pkg.sv
rtl/core/pcbql_ctrl.sv
rtl/core/pcbql_dp.sv
rtl/core/per_class_byte_quota_ledger_core.sv
test/per_class_byte_quota_ledger_checker.sv
test/per_class_byte_quota_ledger_core_test.sv
